// ----- rtl/ovw_pkg.sv -----
// shared types, codes and defaults for the outline vertex welder
package ovw_pkg;

    // parameter defaults
    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 16;

    // fixed field widths
    localparam int IDX_OUT_W = 8;
    localparam int FIELD_W   = 16;
    localparam int RADIUS_W  = 8;
    localparam int KIND_W    = 3;

    // request codes
    localparam logic [KIND_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [KIND_W-1:0] REQ_MOVE  = 3'd1;
    localparam logic [KIND_W-1:0] REQ_LINE  = 3'd2;
    localparam logic [KIND_W-1:0] REQ_CONIC = 3'd3;

    // event codes
    typedef enum logic [KIND_W-1:0] {
        EV_ADDED       = 3'd0,
        EV_LINE        = 3'd1,
        EV_CURVE       = 3'd2,
        EV_CONTOUR     = 3'd3,
        EV_CLEARED     = 3'd4,
        EV_UNSUPPORTED = 3'd5,
        EV_FULL        = 3'd6
    } ev_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_C,
        S_ADD_C,
        S_SCAN_E,
        S_ADD_E,
        S_FINISH,
        S_FULL
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clear;
        logic scan_start;
        logic scan_run;
        logic pt_ctrl;
        logic add;
        logic lat_c;
        logic lat_e;
        logic lat_cnt;
        logic set_prev;
        logic inc_contour;
        logic emit;
        ev_t  ev;
        logic last;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic              exhausted;
        logic              full;
        logic              out_free;
    } status_t;

endpackage

// ----- rtl/outline_vertex_welder.sv -----
// Outline vertex welder, top level.
// A command is decoded, then one weld scan per point runs over the vertex table at one
// entry per cycle, and each result waits for the output to be free.
// One command is handled at a time; the scans of a conic run one after another, since
// the vertex table has a single read port.
// Reset: rst_n is asynchronous, active low; clears the vertex count, contour total,
// previous index and result valid, and sets the weld radius to 1; table contents stay.
module outline_vertex_welder
    import ovw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // end_x, end_y, ctrl_x, ctrl_y
    input  logic [KIND_W-1:0]   s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,   // index_a, index_b, index_c, vertex_x, vertex_y,
                                           // contours_seen
    output logic [KIND_W-1:0]   m_tuser,   // event_kind
    output logic                m_tlast,   // last_of_run
    input  logic                cfg_we,
    input  logic [RADIUS_W-1:0] cfg_wdata  // weld_radius_sq
);

    cmd_t    cmd;
    status_t status;

    // controller
    ovw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ovw_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_kind      (s_tuser),
        .in_end_x     (s_tdata[15:0]),
        .in_end_y     (s_tdata[31:16]),
        .in_ctrl_x    (s_tdata[47:32]),
        .in_ctrl_y    (s_tdata[63:48]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_kind     (m_tuser),
        .out_index_a  (m_tdata[7:0]),
        .out_index_b  (m_tdata[15:8]),
        .out_index_c  (m_tdata[23:16]),
        .out_vertex_x (m_tdata[39:24]),
        .out_vertex_y (m_tdata[55:40]),
        .out_contours (m_tdata[71:56]),
        .out_last     (m_tlast)
    );

endmodule

// ----- rtl/ovw_ctrl.sv -----
// controller state machine for the outline vertex welder
module ovw_ctrl
    import ovw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    REQ_CLEAR:
                    begin
                        if (status.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    REQ_MOVE, REQ_LINE:
                    begin
                        state_next = S_SCAN_E;
                    end
                    REQ_CONIC:
                    begin
                        state_next = S_SCAN_C;
                    end
                    default:
                    begin
                        if (status.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN_C:
            begin
                if (status.hit)
                begin
                    state_next = S_SCAN_E;
                end
                else if (status.exhausted)
                begin
                    state_next = status.full ? S_FULL : S_ADD_C;
                end
            end
            S_ADD_C:
            begin
                if (status.out_free)
                begin
                    state_next = S_SCAN_E;
                end
            end
            S_SCAN_E:
            begin
                if (status.hit)
                begin
                    state_next = S_FINISH;
                end
                else if (status.exhausted)
                begin
                    state_next = status.full ? S_FULL : S_ADD_E;
                end
            end
            S_ADD_E:
            begin
                if (status.out_free)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH, S_FULL:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.ev   = EV_ADDED;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    REQ_CLEAR:
                    begin
                        cmd.clear = status.out_free;
                        cmd.emit  = status.out_free;
                        cmd.ev    = EV_CLEARED;
                        cmd.last  = 1'b1;
                    end
                    REQ_MOVE, REQ_LINE:
                    begin
                        cmd.scan_start = 1'b1;
                    end
                    REQ_CONIC:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.pt_ctrl    = 1'b1;
                    end
                    default:
                    begin
                        cmd.emit = status.out_free;
                        cmd.ev   = EV_UNSUPPORTED;
                        cmd.last = 1'b1;
                    end
                endcase
            end
            S_SCAN_C:
            begin
                cmd.pt_ctrl    = 1'b1;
                cmd.scan_run   = 1'b1;
                cmd.lat_c      = status.hit;
                cmd.scan_start = status.hit;
            end
            S_ADD_C:
            begin
                cmd.pt_ctrl    = 1'b1;
                cmd.add        = status.out_free;
                cmd.lat_c      = status.out_free;
                cmd.lat_cnt    = 1'b1;
                cmd.emit       = status.out_free;
                cmd.ev         = EV_ADDED;
                cmd.scan_start = status.out_free;
            end
            S_SCAN_E:
            begin
                cmd.scan_run = 1'b1;
                cmd.lat_e    = status.hit;
            end
            S_ADD_E:
            begin
                cmd.add     = status.out_free;
                cmd.lat_e   = status.out_free;
                cmd.lat_cnt = 1'b1;
                cmd.emit    = status.out_free;
                cmd.ev      = EV_ADDED;
            end
            S_FINISH:
            begin
                cmd.emit     = status.out_free;
                cmd.last     = 1'b1;
                cmd.set_prev = status.out_free;
                case (status.kind)
                    REQ_MOVE:
                    begin
                        cmd.ev          = EV_CONTOUR;
                        cmd.inc_contour = status.out_free;
                    end
                    REQ_LINE:
                    begin
                        cmd.ev = EV_LINE;
                    end
                    default:
                    begin
                        cmd.ev = EV_CURVE;
                    end
                endcase
            end
            S_FULL:
            begin
                cmd.emit = status.out_free;
                cmd.ev   = EV_FULL;
                cmd.last = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/ovw_datapath.sv -----
// vertex table, weld scan, glyph state and result register
module ovw_datapath
    import ovw_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [KIND_W-1:0]    in_kind,
    input  logic [FIELD_W-1:0]   in_end_x,
    input  logic [FIELD_W-1:0]   in_end_y,
    input  logic [FIELD_W-1:0]   in_ctrl_x,
    input  logic [FIELD_W-1:0]   in_ctrl_y,
    input  logic                 cfg_we,
    input  logic [RADIUS_W-1:0]  cfg_wdata,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [KIND_W-1:0]    out_kind,
    output logic [IDX_OUT_W-1:0] out_index_a,
    output logic [IDX_OUT_W-1:0] out_index_b,
    output logic [IDX_OUT_W-1:0] out_index_c,
    output logic [FIELD_W-1:0]   out_vertex_x,
    output logic [FIELD_W-1:0]   out_vertex_y,
    output logic [FIELD_W-1:0]   out_contours,
    output logic                 out_last
);

    localparam int CB   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTICES);
    localparam logic [FIELD_W-1:0] CONTOUR_SAT = '1;

    // vertex table, y in the upper half
    logic [2*CB-1:0] mem [MAX_VERTICES];
    logic [2*CB-1:0] rd_data_reg;

    // latched request
    logic [KIND_W-1:0] kind_reg;
    logic [CB-1:0]     ex_reg, ey_reg, cx_reg, cy_reg;

    // glyph state
    logic [CNTW-1:0]      count_reg;
    logic [IDX_OUT_W-1:0] prev_reg;
    logic [FIELD_W-1:0]   contour_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [IDXW-1:0]      c_idx_reg, e_idx_reg;

    // scan pipeline
    logic [CNTW-1:0] addr_reg;
    logic            pipe_vld_reg;
    logic [IDXW-1:0] pipe_idx_reg;
    logic            addr_lt;

    // result register
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [IDX_OUT_W-1:0] out_a_reg, out_b_reg, out_c_reg;
    logic [FIELD_W-1:0]   out_x_reg, out_y_reg, out_cnt_reg;
    logic                 out_last_reg;

    logic [CB-1:0]        px, py;
    logic [CB:0]          dx, dy, adx, ady;
    logic [8:0]           dist_sq;
    logic                 near;
    logic                 out_free;
    logic [IDXW-1:0]      lat_idx;
    logic [FIELD_W-1:0]   contour_inc;
    logic [IDX_OUT_W-1:0] ev_a, ev_b, ev_c;
    logic [FIELD_W-1:0]   ev_x, ev_y, ev_cnt;

    // point under test
    assign px = cmd.pt_ctrl ? cx_reg : ex_reg;
    assign py = cmd.pt_ctrl ? cy_reg : ey_reg;

    // squared distance against the entry just read
    always_comb
    begin
        dx  = {px[CB-1], px} - {rd_data_reg[CB-1], rd_data_reg[CB-1:0]};
        dy  = {py[CB-1], py} - {rd_data_reg[2*CB-1], rd_data_reg[2*CB-1:CB]};
        adx = dx[CB] ? (~dx + 1'b1) : dx;
        ady = dy[CB] ? (~dy + 1'b1) : dy;
        dist_sq = 9'(8'(adx[3:0]) * 8'(adx[3:0])) + 9'(8'(ady[3:0]) * 8'(ady[3:0]));
        near = (adx[CB:4] == '0) && (ady[CB:4] == '0) && (dist_sq <= {1'b0, radius_reg});
    end

    assign addr_lt  = (addr_reg < count_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign status.kind      = kind_reg;
    assign status.hit       = pipe_vld_reg && near;
    assign status.exhausted = !pipe_vld_reg && !addr_lt;
    assign status.full      = (count_reg == CNT_MAX);
    assign status.out_free  = out_free;

    assign lat_idx     = cmd.lat_cnt ? count_reg[IDXW-1:0] : pipe_idx_reg;
    assign contour_inc = (contour_reg == CONTOUR_SAT) ? contour_reg : contour_reg + 1'b1;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= in_kind;
            ex_reg   <= in_end_x[CB-1:0];
            ey_reg   <= in_end_y[CB-1:0];
            cx_reg   <= in_ctrl_x[CB-1:0];
            cy_reg   <= in_ctrl_y[CB-1:0];
        end
    end

    // vertex table write and scan read
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            mem[count_reg[IDXW-1:0]] <= {py, px};
        end
        if (cmd.scan_run && addr_lt)
        begin
            rd_data_reg  <= mem[addr_reg[IDXW-1:0]];
            pipe_idx_reg <= addr_reg[IDXW-1:0];
        end
    end

    // scan address and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            addr_reg     <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            pipe_vld_reg <= addr_lt;
            if (addr_lt)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    // welded indices of the current command
    always_ff @(posedge clk)
    begin
        if (cmd.lat_c)
        begin
            c_idx_reg <= lat_idx;
        end
        if (cmd.lat_e)
        begin
            e_idx_reg <= lat_idx;
        end
    end

    // glyph state and weld radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            prev_reg    <= '0;
            contour_reg <= '0;
            radius_reg  <= RADIUS_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                count_reg   <= '0;
                prev_reg    <= '0;
                contour_reg <= '0;
            end
            else
            begin
                if (cmd.add)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cmd.set_prev)
                begin
                    prev_reg <= IDX_OUT_W'(e_idx_reg);
                end
                if (cmd.inc_contour)
                begin
                    contour_reg <= contour_inc;
                end
            end
        end
    end

    // result fields by event
    always_comb
    begin
        ev_a   = '0;
        ev_b   = '0;
        ev_c   = '0;
        ev_x   = '0;
        ev_y   = '0;
        ev_cnt = contour_reg;
        case (cmd.ev)
            EV_ADDED:
            begin
                ev_a = IDX_OUT_W'(count_reg[IDXW-1:0]);
                ev_x = FIELD_W'(signed'(px));
                ev_y = FIELD_W'(signed'(py));
            end
            EV_LINE:
            begin
                ev_a = prev_reg;
                ev_b = IDX_OUT_W'(e_idx_reg);
            end
            EV_CURVE:
            begin
                ev_a = prev_reg;
                ev_b = IDX_OUT_W'(c_idx_reg);
                ev_c = IDX_OUT_W'(e_idx_reg);
            end
            EV_CONTOUR:
            begin
                ev_a   = IDX_OUT_W'(e_idx_reg);
                ev_cnt = contour_inc;
            end
            EV_CLEARED:
            begin
                ev_cnt = '0;
            end
            default:
            begin
                ev_cnt = contour_reg;
            end
        endcase
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.ev;
            out_a_reg    <= ev_a;
            out_b_reg    <= ev_b;
            out_c_reg    <= ev_c;
            out_x_reg    <= ev_x;
            out_y_reg    <= ev_y;
            out_cnt_reg  <= ev_cnt;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_index_a  = out_a_reg;
    assign out_index_b  = out_b_reg;
    assign out_index_c  = out_c_reg;
    assign out_vertex_x = out_x_reg;
    assign out_vertex_y = out_y_reg;
    assign out_contours = out_cnt_reg;
    assign out_last     = out_last_reg;

endmodule
